@@ sv/crc16fr_pkg.sv @@
// Package: phase codes, framing constants and the CRC-16/X.25 byte update.
`timescale 1ns / 1ps

package crc16fr_pkg;

    localparam logic [7:0]  SYNC_BYTE = 8'hFF;
    localparam logic [15:0] CRC_POLY  = 16'h8408;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;

    localparam int TDATA_W = 24;
    localparam int TUSER_W = 2;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_SEQ    = 3'd1,
        PH_LEN    = 3'd2,
        PH_DATA   = 3'd3,
        PH_CHK_HI = 3'd4,
        PH_CHK_LO = 3'd5
    } phase_t;

    // Reflected CRC update over one byte, least significant bit first.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic [7:0]  d;
        c = crc;
        d = b;
        for (int k = 0; k < 8; k++) begin
            if (c[0] ^ d[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
            d = d >> 1;
        end
        return c;
    endfunction

endpackage

@@ sv/crc16_frame_receiver.sv @@
// Top level: length-prefixed frame receiver with CRC-16/X.25 check.
`timescale 1ns / 1ps

// Usage
// -----
// s_ channel: one received serial byte per word on s_tdata. Bytes are
//   dropped until the sync byte 0xFF; then come sequence, length, that many
//   payload bytes and two check bytes (high byte of the complemented CRC
//   first). A sync byte inside a frame is ordinary frame data.
// m_ channel: one word for each payload byte (m_tuser[0] set, byte in
//   m_tdata[7:0]) and one closing word per frame with m_tlast set, the good
//   flag on m_tuser[1], sequence and length in m_tdata. Other bytes give no
//   word. After a bad check, hunting resumes at the next byte.
// Path: an accepted byte lands in the input register and is processed
//   from there into the output register, which offers its word.
// Throughput: one byte per cycle unless the output stalls; the unrolled 8-bit
//   CRC update and the phase logic sit between the input and output registers.
// Stall: when m_tready is low with a word held, a byte that needs an output
//   slot waits in the input register and s_tready drops; bytes that yield
//   no word still drain.
// Reset (aresetn low, synchronous): hunting phase, CRC at 0xFFFF, both
//   registers empty.
module crc16_frame_receiver (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] rx_byte
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [7:0] out_byte, [15:8] seq_number, [23:16] payload_length
    output logic [crc16fr_pkg::TDATA_W-1:0] m_tdata,
    // [0] is_payload, [1] frame_good
    output logic [crc16fr_pkg::TUSER_W-1:0] m_tuser,
    output logic                        m_tlast    // frame_end
);
    import crc16fr_pkg::*;

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // Frame state
    phase_t      phase_reg,  phase_next;
    logic [15:0] crc_reg,    crc_next;
    logic [7:0]  left_reg,   left_next;
    logic [7:0]  seq_reg,    seq_next;
    logic [7:0]  len_reg,    len_next;
    logic [7:0]  chk_hi_reg, chk_hi_next;

    // Output register
    logic                m_valid_reg;
    logic [TDATA_W-1:0]  m_data_reg, m_data_next;
    logic [TUSER_W-1:0]  m_user_reg, m_user_next;
    logic                m_last_reg, m_last_next;

    logic        emit;
    logic        out_free;
    logic        advance;
    logic [15:0] crc_upd;
    logic [15:0] crc_fin;
    logic [7:0]  left_dec;

    assign crc_upd  = crc_feed(crc_reg, in_byte_reg);
    assign crc_fin  = ~crc_reg;
    assign left_dec = left_reg - 8'd1;

    // Phase decode and result build
    always_comb begin
        phase_next  = phase_reg;
        crc_next    = crc_reg;
        left_next   = left_reg;
        seq_next    = seq_reg;
        len_next    = len_reg;
        chk_hi_next = chk_hi_reg;
        emit        = 1'b0;
        m_data_next = '0;
        m_user_next = '0;
        m_last_next = 1'b0;
        case (phase_reg)
            PH_SEQ: begin
                crc_next   = crc_upd;
                seq_next   = in_byte_reg;
                phase_next = PH_LEN;
            end
            PH_LEN: begin
                crc_next   = crc_upd;
                len_next   = in_byte_reg;
                left_next  = in_byte_reg;
                phase_next = (in_byte_reg == 8'd0) ? PH_CHK_HI : PH_DATA;
            end
            PH_DATA: begin
                crc_next         = crc_upd;
                left_next        = left_dec;
                if (left_dec == 8'd0) begin
                    phase_next = PH_CHK_HI;
                end
                emit             = 1'b1;
                m_data_next[7:0] = in_byte_reg;
                m_user_next[0]   = 1'b1;
            end
            PH_CHK_HI: begin
                chk_hi_next = in_byte_reg;
                phase_next  = PH_CHK_LO;
            end
            PH_CHK_LO: begin
                emit               = 1'b1;
                m_last_next        = 1'b1;
                m_user_next[1]     = (chk_hi_reg == crc_fin[15:8]) &&
                                     (in_byte_reg == crc_fin[7:0]);
                m_data_next[15:8]  = seq_reg;
                m_data_next[23:16] = len_reg;
                phase_next         = PH_HUNT;
                crc_next           = CRC_INIT;
            end
            default: begin
                // hunt: drop anything but the sync byte
                if (in_byte_reg == SYNC_BYTE) begin
                    crc_next   = crc_feed(CRC_INIT, in_byte_reg);
                    phase_next = PH_SEQ;
                end else begin
                    phase_next = PH_HUNT;
                end
            end
        endcase
    end

    // Advance when the held byte either yields no word or has a free slot
    assign out_free = !m_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!emit || out_free);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HUNT;
            crc_reg    <= CRC_INIT;
            left_reg   <= 8'd0;
            seq_reg    <= 8'd0;
            len_reg    <= 8'd0;
            chk_hi_reg <= 8'd0;
        end else if (advance) begin
            phase_reg  <= phase_next;
            crc_reg    <= crc_next;
            left_reg   <= left_next;
            seq_reg    <= seq_next;
            len_reg    <= len_next;
            chk_hi_reg <= chk_hi_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (advance && emit) begin
            m_data_reg <= m_data_next;
            m_user_reg <= m_user_next;
            m_last_reg <= m_last_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    // Checks
    a_payload_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_user_reg[0] |-> !m_last_reg)
        else $error("payload word marked as frame end");

    a_payload_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_user_reg[0] |-> (m_data_reg[23:8] == 16'd0) && !m_user_reg[1])
        else $error("payload word carries frame-end fields");

    a_data_has_left: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DATA |-> left_reg != 8'd0)
        else $error("data phase with no bytes left");

    a_hunt_crc_init: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_HUNT |-> crc_reg == CRC_INIT)
        else $error("CRC not at initial value while hunting");

    a_emit_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && emit |=> m_valid_reg)
        else $error("result lost on its way to the output register");

endmodule

@@ bench/tb_crc16_frame_receiver.sv @@
// Testbench for crc16_frame_receiver: framed byte traffic, byte-level prediction, word checks.
`timescale 1ns / 1ps

module tb_crc16_frame_receiver;
    import crc16fr_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE_CYCLES = 8;     // settle time after the last due word is back
    localparam int RANDOM_BYTES = 680;    // framed bytes in the random part
    localparam int QUIET_TAIL = 100;      // last framed bytes sent without idling
    localparam int MAX_PRINTED = 40;

    typedef enum int {
        CHK_INTACT,
        CHK_BAD_HI,
        CHK_BAD_LO
    } check_spoil_t;

    // One word on the m_ channel, as the frame tracker expects it.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_payload;
        logic       frame_end;
        logic       frame_good;
        logic [7:0] seq_number;
        logic [7:0] payload_length;
    } rx_word_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic [7:0] s_tdata = 8'h00;
    logic m_tready = 1'b0;
    logic s_tready;
    logic m_tvalid;
    logic [TDATA_W-1:0] m_tdata;   // [7:0] out_byte, [15:8] seq_number, [23:16] payload_length
    logic [TUSER_W-1:0] m_tuser;   // [0] is_payload, [1] frame_good
    logic m_tlast;                 // frame_end

    crc16_frame_receiver i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 0;
    end

    // Frame tracker state: a private copy of the receiver's phase and CRC.
    phase_t      trk_phase  = PH_HUNT;
    logic [15:0] trk_crc    = CRC_INIT;
    logic [7:0]  trk_left   = 8'h00;
    logic [7:0]  trk_seq    = 8'h00;
    logic [7:0]  trk_len    = 8'h00;
    logic [7:0]  trk_chk_hi = 8'h00;

    rx_word_t rx_words_due[$];

    bit idle_on = 1'b0;
    int errors = 0;
    int cycle_count = 0;
    int frames_sent = 0;
    int frames_spoilt = 0;
    int noise_bytes = 0;
    int framed_bytes = 0;
    int words_checked = 0;
    int payload_words = 0;
    int closes_good = 0;
    int closes_bad = 0;
    int stall_left = 0;

    // CRC-16/X.25 over one byte: fold the byte into the low end, then shift it out.
    function automatic logic [15:0] x25_step(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        r = acc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    // Advance the tracker by one accepted byte and queue any word it yields.
    task automatic track_rx_byte(input logic [7:0] b);
        rx_word_t w;
        logic [15:0] fin;
        w = '0;
        case (trk_phase)
            PH_SEQ: begin
                trk_crc = x25_step(trk_crc, b);
                trk_seq = b;
                trk_phase = PH_LEN;
            end
            PH_LEN: begin
                trk_crc = x25_step(trk_crc, b);
                trk_len = b;
                trk_left = b;
                trk_phase = (b == 8'h00) ? PH_CHK_HI : PH_DATA;
            end
            PH_DATA: begin
                trk_crc = x25_step(trk_crc, b);
                trk_left = trk_left - 8'd1;
                if (trk_left == 8'h00) begin
                    trk_phase = PH_CHK_HI;
                end
                w.out_byte = b;
                w.is_payload = 1'b1;
                rx_words_due.push_back(w);
            end
            PH_CHK_HI: begin
                trk_chk_hi = b;
                trk_phase = PH_CHK_LO;
            end
            PH_CHK_LO: begin
                fin = ~trk_crc;
                w.frame_end = 1'b1;
                w.frame_good = ({trk_chk_hi, b} == fin);
                w.seq_number = trk_seq;
                w.payload_length = trk_len;
                rx_words_due.push_back(w);
                trk_phase = PH_HUNT;
                trk_crc = CRC_INIT;
            end
            default: begin
                // hunting: only the sync byte opens a frame
                if (b == SYNC_BYTE) begin
                    trk_crc = x25_step(CRC_INIT, b);
                    trk_phase = PH_SEQ;
                end else begin
                    trk_phase = PH_HUNT;
                end
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= MAX_PRINTED) begin
            $display("MISMATCH %s: got %0h, expected %0h (word %0d)",
                     what, got, want, words_checked);
        end
    endtask

    // Compare one accepted word with the oldest one due.
    task automatic check_word();
        rx_word_t want;
        words_checked++;
        if (m_tuser[0]) begin
            payload_words++;
        end
        if (m_tlast) begin
            if (m_tuser[1]) begin
                closes_good++;
            end else begin
                closes_bad++;
            end
        end
        if (rx_words_due.size() == 0) begin
            report_mismatch("word with nothing due", m_tdata, 0);
            return;
        end
        want = rx_words_due.pop_front();
        if (m_tdata[7:0] != want.out_byte)
            report_mismatch("out_byte", m_tdata[7:0], want.out_byte);
        if (m_tuser[0] != want.is_payload)
            report_mismatch("is_payload", m_tuser[0], want.is_payload);
        if (m_tlast != want.frame_end)
            report_mismatch("frame_end", m_tlast, want.frame_end);
        if (m_tuser[1] != want.frame_good)
            report_mismatch("frame_good", m_tuser[1], want.frame_good);
        if (m_tdata[15:8] != want.seq_number)
            report_mismatch("seq_number", m_tdata[15:8], want.seq_number);
        if (m_tdata[23:16] != want.payload_length)
            report_mismatch("payload_length", m_tdata[23:16], want.payload_length);
    endtask

    // Result side: check each accepted word, stall in random bursts.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            check_word();
        end
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            stall_left <= $urandom_range(0, 13);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d words still due",
                     cycle_count, rx_words_due.size());
            $display("Verification failed");
            $finish;
        end
    end

    // Offer one byte, hold it until taken, then advance the tracker.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        track_rx_byte(b);
    endtask

    // Send a complete frame; optionally flip one bit of either check byte.
    task automatic send_frame(input logic [7:0] seq, input logic [7:0] len,
                              input check_spoil_t spoil, input bit all_sync);
        logic [15:0] acc;
        logic [15:0] chk;
        logic [7:0]  b;
        acc = x25_step(CRC_INIT, SYNC_BYTE);
        send_byte(SYNC_BYTE);
        acc = x25_step(acc, seq);
        send_byte(seq);
        acc = x25_step(acc, len);
        send_byte(len);
        for (int i = 0; i < len; i++) begin
            if (all_sync || $urandom_range(0, 7) == 0) begin
                b = SYNC_BYTE;
            end else begin
                b = 8'($urandom);
            end
            acc = x25_step(acc, b);
            send_byte(b);
        end
        chk = ~acc;
        if (spoil == CHK_BAD_HI) begin
            chk = chk ^ (16'h0100 << $urandom_range(0, 7));
        end else if (spoil == CHK_BAD_LO) begin
            chk = chk ^ (16'h0001 << $urandom_range(0, 7));
        end
        send_byte(chk[15:8]);
        send_byte(chk[7:0]);
        frames_sent++;
        framed_bytes += int'(len) + 5;
        if (spoil != CHK_INTACT) begin
            frames_spoilt++;
        end
    endtask

    // Drop valid and hold off until every due word is back, then let the pipe settle.
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (rx_words_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Bytes before any sync are dropped without a word.
    task automatic test_hunt_noise();
        send_byte(8'h00);
        send_byte(8'hFE);
        noise_bytes += 2;
    endtask

    // Check bytes follow the length byte directly.
    task automatic test_zero_length();
        send_frame(8'h00, 8'h00, CHK_INTACT, 1'b0);
    endtask

    // Sync bytes as sequence and payload are plain frame data.
    task automatic test_sync_in_frame();
        send_frame(8'hFF, 8'd3, CHK_INTACT, 1'b1);
    endtask

    // Damage each check byte in turn; hunting must resume straight after.
    task automatic test_bad_check();
        send_frame(8'h5A, 8'd1, CHK_BAD_HI, 1'b0);
        send_frame(8'hA5, 8'd0, CHK_BAD_LO, 1'b0);
    endtask

    // Mostly well-formed frames of small length, some damaged, some noise,
    // the odd long frame; pause once mid-way until everything has drained.
    task automatic test_random_traffic();
        int sel;
        int start_bytes;
        bit paused;
        logic [7:0] len;
        check_spoil_t spoil;
        start_bytes = framed_bytes;
        paused = 1'b0;
        while (framed_bytes - start_bytes < RANDOM_BYTES) begin
            if (framed_bytes - start_bytes < RANDOM_BYTES - QUIET_TAIL) begin
                idle_on = ($urandom_range(0, 3) != 0);
            end else begin
                idle_on = 1'b0;
            end
            if (!paused && framed_bytes - start_bytes > RANDOM_BYTES / 2) begin
                wait_for_drain();
                paused = 1'b1;
            end
            sel = $urandom_range(0, 19);
            if (sel < 2) begin
                repeat ($urandom_range(1, 4)) begin
                    send_byte(8'($urandom));
                    noise_bytes++;
                end
            end else begin
                if ($urandom_range(0, 49) == 0) begin
                    len = $urandom_range(0, 1) ? 8'd255 : 8'($urandom_range(100, 254));
                end else begin
                    len = 8'($urandom_range(0, 12));
                end
                if (sel < 4) begin
                    spoil = $urandom_range(0, 1) ? CHK_BAD_HI : CHK_BAD_LO;
                end else begin
                    spoil = CHK_INTACT;
                end
                send_frame(8'($urandom), len, spoil, 1'b0);
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        idle_on = 1'b1;
        test_hunt_noise();
        test_zero_length();
        test_sync_in_frame();
        test_bad_check();
        wait_for_drain();
        test_random_traffic();
        idle_on = 1'b0;
        wait_for_drain();
        $display("Sent %0d frames (%0d with a damaged check), %0d noise bytes, %0d framed bytes",
                 frames_sent, frames_spoilt, noise_bytes, framed_bytes);
        $display("Checked %0d words: %0d payload, %0d good closes, %0d bad closes",
                 words_checked, payload_words, closes_good, closes_bad);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
